// ===== src/egb_pkg.sv =====
// Package for the extended GCD unit: field widths, control word layout and the microprogram.
// It depends on nothing and is used by the top level.
package egb_pkg;

	localparam int OPERAND_W = 63;
	localparam int DIVISOR_W = 63;
	localparam int COEF_W    = 64;
	localparam int PC_W      = 3;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		OP_LOAD   = 3'd0,
		OP_INIT   = 3'd1,
		OP_DIV    = 3'd2,
		OP_UPDATE = 3'd3,
		OP_EMIT   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CND_ALWAYS    = 3'd0,
		CND_IN_VALID  = 3'd1,
		CND_RCUR_ZERO = 3'd2,
		CND_CNT_ZERO  = 3'd3,
		CND_OUT_FREE  = 3'd4
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  hold;
		pc_t   target;
	} ctrl_word_t;

	localparam pc_t PC_IDLE   = 3'd0;
	localparam pc_t PC_TEST   = 3'd1;
	localparam pc_t PC_DIVIDE = 3'd2;
	localparam pc_t PC_UPDATE = 3'd3;
	localparam pc_t PC_EMIT   = 3'd4;

	// When the condition holds the sequencer jumps to the target; otherwise it
	// either stays on the step or falls through to the next one.
	function automatic ctrl_word_t rom_word(input pc_t pc);
		ctrl_word_t w;
		w = '{op: OP_EMIT, cond: CND_ALWAYS, hold: 1'b0, target: PC_IDLE};
		case (pc)
			PC_IDLE:   w = '{op: OP_LOAD,   cond: CND_IN_VALID,  hold: 1'b1, target: PC_TEST};
			PC_TEST:   w = '{op: OP_INIT,   cond: CND_RCUR_ZERO, hold: 1'b0, target: PC_EMIT};
			PC_DIVIDE: w = '{op: OP_DIV,    cond: CND_CNT_ZERO,  hold: 1'b1, target: PC_UPDATE};
			PC_UPDATE: w = '{op: OP_UPDATE, cond: CND_ALWAYS,    hold: 1'b0, target: PC_TEST};
			PC_EMIT:   w = '{op: OP_EMIT,   cond: CND_OUT_FREE,  hold: 1'b1, target: PC_IDLE};
			default:   w = '{op: OP_EMIT,   cond: CND_ALWAYS,    hold: 1'b0, target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== src/extended_gcd_bezout_unit.sv =====
// Extended Euclid unit: greatest common divisor and Bezout coefficients of two operands.
// A microcoded sequencer drives a bit-serial divider with coefficient accumulators.
// Depends on egb_pkg.
//
//   channel  direction  payload                      handshake
//   in       request    operand_a, operand_b         in_valid / in_ready
//   out      result     divisor, coef_a, coef_b      out_valid / out_ready
//
// Each Euclid step runs a test and init step, then one restoring division bit per cycle,
// with the quotient times each coefficient built up alongside it, then an update step.
// One request is worked on at a time; the next is taken while the result waits.
// Reset clears the program counter and the output valid flag; the datapath registers are not reset.
module extended_gcd_bezout_unit
	import egb_pkg::*;
#(
	parameter int OPERAND_BITS = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OPERAND_W-1:0] operand_a,
	input  logic [OPERAND_W-1:0] operand_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIVISOR_W-1:0] divisor,
	output logic [COEF_W-1:0]    coef_a,
	output logic [COEF_W-1:0]    coef_b
);

	localparam int CNT_W = $clog2(OPERAND_BITS);

	pc_t                     pc_q;
	ctrl_word_t              cw;
	logic                    cond_ok;
	logic                    out_valid_q;
	logic [OPERAND_BITS-1:0] r_prev_q, r_cur_q, rem_q, dvd_q;
	logic [COEF_W-1:0]       s_prev_q, s_cur_q, t_prev_q, t_cur_q, acc_s_q, acc_t_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIVISOR_W-1:0]    divisor_q;
	logic [COEF_W-1:0]       coef_a_q, coef_b_q;
	logic [OPERAND_BITS:0]   trial, diff;
	logic                    qbit;
	logic [OPERAND_BITS-1:0] rem_next;

	assign cw = rom_word(pc_q);

	always_comb begin
		case (cw.cond)
			CND_ALWAYS:    cond_ok = 1'b1;
			CND_IN_VALID:  cond_ok = in_valid;
			CND_RCUR_ZERO: cond_ok = (r_cur_q == '0);
			CND_CNT_ZERO:  cond_ok = (cnt_q == '0);
			CND_OUT_FREE:  cond_ok = !out_valid_q || out_ready;
			default:       cond_ok = 1'b1;
		endcase
	end

	assign trial    = {rem_q, dvd_q[OPERAND_BITS-1]};
	assign diff     = trial - {1'b0, r_cur_q};
	assign qbit     = !diff[OPERAND_BITS];
	assign rem_next = qbit ? diff[OPERAND_BITS-1:0] : trial[OPERAND_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cond_ok) begin
				pc_q <= cw.target;
			end else if (!cw.hold) begin
				pc_q <= pc_t'(pc_q + 1'b1);
			end
			if (cw.op == OP_EMIT && cond_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_LOAD: begin
				if (cond_ok) begin
					r_prev_q <= operand_a[OPERAND_BITS-1:0];
					r_cur_q  <= operand_b[OPERAND_BITS-1:0];
					s_prev_q <= COEF_W'(1);
					s_cur_q  <= '0;
					t_prev_q <= '0;
					t_cur_q  <= COEF_W'(1);
				end
			end
			OP_INIT: begin
				rem_q   <= '0;
				dvd_q   <= r_prev_q;
				acc_s_q <= '0;
				acc_t_q <= '0;
				cnt_q   <= CNT_W'(OPERAND_BITS - 1);
			end
			OP_DIV: begin
				rem_q   <= rem_next;
				dvd_q   <= {dvd_q[OPERAND_BITS-2:0], 1'b0};
				acc_s_q <= {acc_s_q[COEF_W-2:0], 1'b0} + (qbit ? s_cur_q : '0);
				acc_t_q <= {acc_t_q[COEF_W-2:0], 1'b0} + (qbit ? t_cur_q : '0);
				cnt_q   <= cnt_q - 1'b1;
			end
			OP_UPDATE: begin
				r_prev_q <= r_cur_q;
				r_cur_q  <= rem_q;
				s_prev_q <= s_cur_q;
				s_cur_q  <= s_prev_q - acc_s_q;
				t_prev_q <= t_cur_q;
				t_cur_q  <= t_prev_q - acc_t_q;
			end
			OP_EMIT: begin
				if (cond_ok) begin
					divisor_q <= DIVISOR_W'(r_prev_q);
					coef_a_q  <= s_prev_q;
					coef_b_q  <= t_prev_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (pc_q == PC_IDLE);
	assign out_valid = out_valid_q;
	assign divisor   = divisor_q;
	assign coef_a    = coef_a_q;
	assign coef_b    = coef_b_q;

endmodule

// ===== src/egb_checker.sv =====
// Port-level checker for the extended GCD unit, bound to its top level.
// Depends on egb_pkg.
module egb_checker
	import egb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [DIVISOR_W-1:0] divisor,
	input logic [COEF_W-1:0]    coef_a,
	input logic [COEF_W-1:0]    coef_b
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(divisor) && $stable(coef_a)
			&& $stable(coef_b))
		else $error("result changed while stalled");

	// Once a request is taken the unit is busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// A result only appears at the end of work, never from the idle step.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

	// A zero divisor only arises from two zero operands, giving coefficients one and zero.
	a_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor == '0 |-> coef_a == COEF_W'(1) && coef_b == '0)
		else $error("bad coefficients for zero divisor");

endmodule

bind extended_gcd_bezout_unit egb_checker u_egb_checker (.*);
